@@ sv/cubemap_face_uv_select_assert.svh @@
// assertion macros used by the port-level checker of the cube-map face block
`ifndef CUBEMAP_FACE_UV_SELECT_ASSERT_SVH
`define CUBEMAP_FACE_UV_SELECT_ASSERT_SVH

// same-cycle implication, masked during reset
`define CFUV_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cfuv assertion failed");

// next-cycle implication, masked during reset
`define CFUV_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cfuv assertion failed");

// implication checked in every cycle, reset included
`define CFUV_ASSERT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("cfuv assertion failed");

`endif

@@ sv/cfuv_pkg.sv @@
// ----------------------------------------------------------------------------
// cfuv_pkg
// shared types and constants of the cube-map face select block
// ----------------------------------------------------------------------------
`default_nettype none

package cfuv_pkg;

    localparam int CompBitsDefault  = 16;
    localparam int CoordFracDefault = 16;
    localparam int FaceBits         = 3;

    // face index codes
    typedef enum logic [FaceBits-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } cfuv_face_t;

    // control that travels with every item down the divider chain
    typedef struct packed {
        logic       valid;
        cfuv_face_t face;
        logic       sat_u;
        logic       sat_v;
        logic       degen;
    } cfuv_ctrl_t;

endpackage

`default_nettype wire

@@ sv/cfuv_front.sv @@
// ----------------------------------------------------------------------------
// cfuv_front
// major axis pick, per-face sign selection, numerators and denominator
// ----------------------------------------------------------------------------
`default_nettype none

module cfuv_front #(
    parameter int COMPONENT_BITS = cfuv_pkg::CompBitsDefault
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [COMPONENT_BITS-1:0]   dir_x,
    input  wire logic [COMPONENT_BITS-1:0]   dir_y,
    input  wire logic [COMPONENT_BITS-1:0]   dir_z,
    output cfuv_pkg::cfuv_ctrl_t             ctrl,
    output logic      [COMPONENT_BITS:0]     num_u,
    output logic      [COMPONENT_BITS:0]     num_v,
    output logic      [COMPONENT_BITS:0]     den
);

    localparam int CB = COMPONENT_BITS;

    logic signed [CB:0]   xe, ye, ze;
    logic signed [CB:0]   ax_w, ay_w, az_w;
    logic        [CB-1:0] ax, ay, az;
    logic        [CB-1:0] ma;
    logic signed [CB:0]   ma_s;
    logic signed [CB:0]   sc, tc;
    logic signed [CB+1:0] nu_w, nv_w;
    cfuv_pkg::cfuv_face_t face_w;

    cfuv_pkg::cfuv_ctrl_t ctrl_reg, ctrl_next;
    logic [CB:0]          num_u_reg, num_u_next;
    logic [CB:0]          num_v_reg, num_v_next;
    logic [CB:0]          den_reg, den_next;

    always_comb begin
        xe   = {dir_x[CB-1], dir_x};
        ye   = {dir_y[CB-1], dir_y};
        ze   = {dir_z[CB-1], dir_z};
        ax_w = xe[CB] ? -xe : xe;
        ay_w = ye[CB] ? -ye : ye;
        az_w = ze[CB] ? -ze : ze;
        ax   = ax_w[CB-1:0];
        ay   = ay_w[CB-1:0];
        az   = az_w[CB-1:0];

        // strict compares: ties go to y, then to z
        priority if (ax > ay && ax > az) begin
            ma = ax;
            if (!xe[CB] && xe != '0) begin
                face_w = cfuv_pkg::FACE_PX; sc = ze;  tc = ye;
            end else begin
                face_w = cfuv_pkg::FACE_NX; sc = -ze; tc = ye;
            end
        end else if (ay > az) begin
            ma = ay;
            if (!ye[CB] && ye != '0) begin
                face_w = cfuv_pkg::FACE_PY; sc = xe; tc = ze;
            end else begin
                face_w = cfuv_pkg::FACE_NY; sc = xe; tc = -ze;
            end
        end else begin
            ma = az;
            if (!ze[CB] && ze != '0) begin
                face_w = cfuv_pkg::FACE_PZ; sc = -xe; tc = ye;
            end else begin
                face_w = cfuv_pkg::FACE_NZ; sc = xe;  tc = ye;
            end
        end

        ma_s = {1'b0, ma};
        nu_w = {sc[CB], sc} + {2'b00, ma};
        nv_w = {tc[CB], tc} + {2'b00, ma};

        ctrl_next.valid = in_valid;
        ctrl_next.face  = face_w;
        ctrl_next.sat_u = (sc == ma_s);
        ctrl_next.sat_v = (tc == ma_s);
        ctrl_next.degen = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
        num_u_next      = nu_w[CB:0];
        num_v_next      = nv_w[CB:0];
        den_next        = {ma, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_u_reg <= num_u_next;
            num_v_reg <= num_v_next;
            den_reg   <= den_next;
        end
    end

    assign ctrl  = ctrl_reg;
    assign num_u = num_u_reg;
    assign num_v = num_v_reg;
    assign den   = den_reg;

endmodule

`default_nettype wire

@@ sv/cfuv_div_cell.sv @@
// ----------------------------------------------------------------------------
// cfuv_div_cell
// one restoring-division step: one quotient bit for u and for v
// ----------------------------------------------------------------------------
`default_nettype none

module cfuv_div_cell #(
    parameter int COMPONENT_BITS  = cfuv_pkg::CompBitsDefault,
    parameter int COORD_FRAC_BITS = cfuv_pkg::CoordFracDefault
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire cfuv_pkg::cfuv_ctrl_t          ctrl_in,
    input  wire logic [COMPONENT_BITS:0]       den_in,
    input  wire logic [COMPONENT_BITS:0]       rem_u_in,
    input  wire logic [COMPONENT_BITS:0]       rem_v_in,
    input  wire logic [COORD_FRAC_BITS-1:0]    quo_u_in,
    input  wire logic [COORD_FRAC_BITS-1:0]    quo_v_in,
    output cfuv_pkg::cfuv_ctrl_t               ctrl_out,
    output logic      [COMPONENT_BITS:0]       den_out,
    output logic      [COMPONENT_BITS:0]       rem_u_out,
    output logic      [COMPONENT_BITS:0]       rem_v_out,
    output logic      [COORD_FRAC_BITS-1:0]    quo_u_out,
    output logic      [COORD_FRAC_BITS-1:0]    quo_v_out
);

    localparam int DW = COMPONENT_BITS + 1;
    localparam int F  = COORD_FRAC_BITS;

    logic [DW:0]   t_u, t_v, den_w;
    logic          ge_u, ge_v;
    logic [DW:0]   d_u, d_v;

    cfuv_pkg::cfuv_ctrl_t ctrl_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_u_reg, rem_u_next;
    logic [DW-1:0] rem_v_reg, rem_v_next;
    logic [F-1:0]  quo_u_reg, quo_u_next;
    logic [F-1:0]  quo_v_reg, quo_v_next;

    always_comb begin
        den_w      = {1'b0, den_in};
        t_u        = {rem_u_in, 1'b0};
        t_v        = {rem_v_in, 1'b0};
        ge_u       = (t_u >= den_w);
        ge_v       = (t_v >= den_w);
        d_u        = t_u - den_w;
        d_v        = t_v - den_w;
        rem_u_next = ge_u ? d_u[DW-1:0] : t_u[DW-1:0];
        rem_v_next = ge_v ? d_v[DW-1:0] : t_v[DW-1:0];
        quo_u_next = {quo_u_in[F-2:0], ge_u};
        quo_v_next = {quo_v_in[F-2:0], ge_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= den_in;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            quo_u_reg <= quo_u_next;
            quo_v_reg <= quo_v_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign den_out   = den_reg;
    assign rem_u_out = rem_u_reg;
    assign rem_v_out = rem_v_reg;
    assign quo_u_out = quo_u_reg;
    assign quo_v_out = quo_v_reg;

endmodule

`default_nettype wire

@@ sv/cubemap_face_uv_select.sv @@
// ----------------------------------------------------------------------------
// cubemap_face_uv_select
// cube-map face select with u/v face coordinates, while the output is not stalled one item per cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: one direction item (x, y, z), signed two's complement,
//   all three on the same scale. result channel m_*: face 0..5 (+x -x +y -y
//   +z -z), u and v as unsigned fractions of 2^COORD_FRAC_BITS, and a flag
//   for the all-zero vector (face 5, u = v = one half).
//   path: from input accept to m_valid an item passes the front register
//   for the axis pick, one division cell per quotient bit and one output
//   register for saturation.
//   throughput: one item per cycle while m_ready is high; the chain of
//   division cells takes a new item each cycle.
//   stall: when the output item is held, the whole chain freezes; one more
//   input item lands in the input skid register and s_ready drops until
//   the chain moves again. s_ready comes straight from a flop.
//   reset: synchronous active-low aresetn empties the chain, the skid
//   register and the output register; s_ready is high right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cubemap_face_uv_select #(
    parameter int COMPONENT_BITS  = cfuv_pkg::CompBitsDefault,
    parameter int COORD_FRAC_BITS = cfuv_pkg::CoordFracDefault
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [COMPONENT_BITS-1:0]    s_dir_x,
    input  wire logic [COMPONENT_BITS-1:0]    s_dir_y,
    input  wire logic [COMPONENT_BITS-1:0]    s_dir_z,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [cfuv_pkg::FaceBits-1:0]     m_face,
    output logic [COORD_FRAC_BITS-1:0]        m_coord_u,
    output logic [COORD_FRAC_BITS-1:0]        m_coord_v,
    output logic                              m_degenerate
);

    localparam int CB = COMPONENT_BITS;
    localparam int F  = COORD_FRAC_BITS;
    localparam int DW = CB + 1;

    localparam logic [F-1:0] CoordHalf = {1'b1, {(F-1){1'b0}}};
    localparam logic [F-1:0] CoordMax  = {F{1'b1}};

    // chain advance: the output slot is free or being taken
    logic en;

    // input skid register
    logic          skid_valid_reg, skid_valid_next;
    logic [CB-1:0] skid_x_reg, skid_y_reg, skid_z_reg;
    logic          src_valid;
    logic [CB-1:0] src_x, src_y, src_z;

    // links between the front stage and the cells
    cfuv_pkg::cfuv_ctrl_t chain_ctrl  [0:F];
    logic [DW-1:0]        chain_den   [0:F];
    logic [DW-1:0]        chain_rem_u [0:F];
    logic [DW-1:0]        chain_rem_v [0:F];
    logic [F-1:0]         chain_quo_u [0:F];
    logic [F-1:0]         chain_quo_v [0:F];

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [cfuv_pkg::FaceBits-1:0] m_face_reg, m_face_next;
    logic [F-1:0]                  m_coord_u_reg, m_coord_u_next;
    logic [F-1:0]                  m_coord_v_reg, m_coord_v_next;
    logic                          m_degenerate_reg, m_degenerate_next;
    cfuv_pkg::cfuv_ctrl_t          last_ctrl;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = !skid_valid_reg;

    // the skid item goes first whenever it is held
    always_comb begin
        src_valid = skid_valid_reg || s_valid;
        src_x     = skid_valid_reg ? skid_x_reg : s_dir_x;
        src_y     = skid_valid_reg ? skid_y_reg : s_dir_y;
        src_z     = skid_valid_reg ? skid_z_reg : s_dir_z;

        priority if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
        end else begin
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    // capture the item that arrives while the chain is frozen
    always_ff @(posedge aclk) begin
        if (!en && s_valid && !skid_valid_reg) begin
            skid_x_reg <= s_dir_x;
            skid_y_reg <= s_dir_y;
            skid_z_reg <= s_dir_z;
        end
    end

    // axis pick and numerator/denominator setup
    cfuv_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (src_valid),
        .dir_x    (src_x),
        .dir_y    (src_y),
        .dir_z    (src_z),
        .ctrl     (chain_ctrl[0]),
        .num_u    (chain_rem_u[0]),
        .num_v    (chain_rem_v[0]),
        .den      (chain_den[0])
    );

    assign chain_quo_u[0] = '0;
    assign chain_quo_v[0] = '0;

    // one cell per quotient bit, msb first
    for (genvar i = 0; i < F; i++) begin : g_cell
        cfuv_div_cell #(
            .COMPONENT_BITS  (COMPONENT_BITS),
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .ctrl_in   (chain_ctrl[i]),
            .den_in    (chain_den[i]),
            .rem_u_in  (chain_rem_u[i]),
            .rem_v_in  (chain_rem_v[i]),
            .quo_u_in  (chain_quo_u[i]),
            .quo_v_in  (chain_quo_v[i]),
            .ctrl_out  (chain_ctrl[i+1]),
            .den_out   (chain_den[i+1]),
            .rem_u_out (chain_rem_u[i+1]),
            .rem_v_out (chain_rem_v[i+1]),
            .quo_u_out (chain_quo_u[i+1]),
            .quo_v_out (chain_quo_v[i+1])
        );
    end

    assign last_ctrl = chain_ctrl[F];

    // zero vector and component equal to +ma override the quotient
    always_comb begin
        m_valid_next      = last_ctrl.valid;
        m_face_next       = last_ctrl.face;
        m_degenerate_next = last_ctrl.degen;
        priority if (last_ctrl.degen) begin
            m_coord_u_next = CoordHalf;
            m_coord_v_next = CoordHalf;
        end else begin
            m_coord_u_next = last_ctrl.sat_u ? CoordMax : chain_quo_u[F];
            m_coord_v_next = last_ctrl.sat_v ? CoordMax : chain_quo_v[F];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_face_reg       <= m_face_next;
            m_coord_u_reg    <= m_coord_u_next;
            m_coord_v_reg    <= m_coord_v_next;
            m_degenerate_reg <= m_degenerate_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_face       = m_face_reg;
    assign m_coord_u    = m_coord_u_reg;
    assign m_coord_v    = m_coord_v_reg;
    assign m_degenerate = m_degenerate_reg;

endmodule

`default_nettype wire

@@ sv/cfuv_checker.sv @@
// ----------------------------------------------------------------------------
// cfuv_checker
// port-level checks of the cube-map face select block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubemap_face_uv_select_assert.svh"

module cfuv_checker #(
    parameter int COORD_FRAC_BITS = cfuv_pkg::CoordFracDefault
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [cfuv_pkg::FaceBits-1:0] m_face,
    input wire logic [COORD_FRAC_BITS-1:0]   m_coord_u,
    input wire logic [COORD_FRAC_BITS-1:0]   m_coord_v,
    input wire logic                         m_degenerate
);

    localparam int PW = cfuv_pkg::FaceBits + 2 * COORD_FRAC_BITS + 1;
    localparam logic [COORD_FRAC_BITS-1:0] CoordHalf =
        {1'b1, {(COORD_FRAC_BITS-1){1'b0}}};

    logic          in_acc;
    logic          out_stall;
    logic          degen_ok;
    logic [PW-1:0] m_payload;
    assign in_acc    = s_valid && s_ready;
    assign out_stall = m_valid && !m_ready;
    assign degen_ok  = (m_face == cfuv_pkg::FACE_NZ) && (m_coord_u == CoordHalf) &&
                       (m_coord_v == CoordHalf);
    assign m_payload = {m_face, m_coord_u, m_coord_v, m_degenerate};

    // held result keeps its payload
    `CFUV_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_payload))

    // zero vector result is fixed
    `CFUV_ASSERT_IMP(a_degen_value, aclk, aresetn, m_valid && m_degenerate, degen_ok)

    // ready drops only after an item was taken during an output stall
    `CFUV_ASSERT_IMP(a_ready_drop, aclk, aresetn, $fell(s_ready), $past(in_acc && out_stall))

    // reset leaves both channels empty and the input open
    `CFUV_ASSERT_ALL(a_reset_state, aclk, $past(!aresetn) && aresetn, s_ready && !m_valid)

endmodule

bind cubemap_face_uv_select cfuv_checker #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
) u_cfuv_checker (.*);

`default_nettype wire

@@ sim/cfuv_face_checker.sv @@
// ----------------------------------------------------------------------------
// cfuv_face_checker
// watches both channels of the cube-map face block, predicts face and u/v
// for every accepted direction and compares each result in order
// ----------------------------------------------------------------------------
module cfuv_face_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [cfuv_pkg::CompBitsDefault-1:0] s_dir_x,
    input  logic [cfuv_pkg::CompBitsDefault-1:0] s_dir_y,
    input  logic [cfuv_pkg::CompBitsDefault-1:0] s_dir_z,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [cfuv_pkg::FaceBits-1:0]        m_face,
    input  logic [cfuv_pkg::CoordFracDefault-1:0] m_coord_u,
    input  logic [cfuv_pkg::CoordFracDefault-1:0] m_coord_v,
    input  logic                                 m_degenerate,
    output int                                   mismatches,
    output int                                   owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = cfuv_pkg::CompBitsDefault;
    localparam int FB = cfuv_pkg::CoordFracDefault;

    typedef struct packed {
        logic [CB-1:0]        dx;
        logic [CB-1:0]        dy;
        logic [CB-1:0]        dz;
        cfuv_pkg::cfuv_face_t face;
        logic [FB-1:0]        u;
        logic [FB-1:0]        v;
        logic                 degen;
    } face_uv_t;

    face_uv_t pending_faces[$];
    face_uv_t want;
    int       bad_results = 0;

    // floor((s + ma) * 2^FB / (2 * ma)), clipped to all ones
    function automatic logic [FB-1:0] face_coord(input longint s, input longint ma);
        longint q;
        longint top;
        top = (longint'(1) <<< FB) - 1;
        q = ((s + ma) <<< FB) / (2 * ma);
        if (q > top) q = top;
        return q[FB-1:0];
    endfunction

    function automatic face_uv_t cube_face_uv(input logic [CB-1:0] rx, ry, rz);
        longint x, y, z, ax, ay, az, ma, sc, tc;
        face_uv_t r;
        x  = longint'($signed(rx));
        y  = longint'($signed(ry));
        z  = longint'($signed(rz));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r.dx = rx;
        r.dy = ry;
        r.dz = rz;
        r.degen = 1'b0;
        if (x == 0 && y == 0 && z == 0) begin
            // no direction at all: -z face, center of the face
            r.face  = cfuv_pkg::FACE_NZ;
            r.u     = '0;
            r.u[FB-1] = 1'b1;
            r.v     = r.u;
            r.degen = 1'b1;
        end else begin
            // strict compares: ties go to y, then to z
            if (ax > ay && ax > az) begin
                ma = ax;
                if (x > 0) begin
                    r.face = cfuv_pkg::FACE_PX; sc = z;  tc = y;
                end else begin
                    r.face = cfuv_pkg::FACE_NX; sc = -z; tc = y;
                end
            end else if (ay > az) begin
                ma = ay;
                if (y > 0) begin
                    r.face = cfuv_pkg::FACE_PY; sc = x; tc = z;
                end else begin
                    r.face = cfuv_pkg::FACE_NY; sc = x; tc = -z;
                end
            end else begin
                ma = az;
                if (z > 0) begin
                    r.face = cfuv_pkg::FACE_PZ; sc = -x; tc = y;
                end else begin
                    r.face = cfuv_pkg::FACE_NZ; sc = x;  tc = y;
                end
            end
            r.u = face_coord(sc, ma);
            r.v = face_coord(tc, ma);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_faces.delete();
        end else begin
            // a result never belongs to the item taken at the same edge
            if (m_valid && m_ready) begin
                if (pending_faces.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: unexpected result face %0d u %0d v %0d degen %0b",
                                 $realtime, m_face, m_coord_u, m_coord_v, m_degenerate);
                end else begin
                    want = pending_faces.pop_front();
                    if (m_face != want.face || m_coord_u != want.u ||
                        m_coord_v != want.v || m_degenerate != want.degen) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"%0t: dir (%0d,%0d,%0d) expected face %0d u %0d v %0d ",
                                      "degen %0b, got face %0d u %0d v %0d degen %0b"},
                                     $realtime, $signed(want.dx), $signed(want.dy),
                                     $signed(want.dz), want.face, want.u, want.v, want.degen,
                                     m_face, m_coord_u, m_coord_v, m_degenerate);
                    end
                end
            end
            if (s_valid && s_ready)
                pending_faces.push_back(cube_face_uv(s_dir_x, s_dir_y, s_dir_z));
        end
        mismatches <= bad_results;
        owed       <= pending_faces.size();
    end

endmodule

@@ sim/cubemap_face_uv_select_tb.sv @@
// ----------------------------------------------------------------------------
// cubemap_face_uv_select_tb
// drives direction items into the cube-map face block with random gaps and
// output stalls, and lets the checker compare every face and u/v result
// ----------------------------------------------------------------------------
module cubemap_face_uv_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = cfuv_pkg::CompBitsDefault;
    localparam int FB           = cfuv_pkg::CoordFracDefault;
    // axis pick, one divider cell per quotient bit, output register
    localparam int LATENCY      = FB + 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PRESS_ITEMS  = 60;
    localparam int RAND_BLOCKS  = 15;
    localparam int BLOCK_ITEMS  = 38;

    logic          aclk         = 1'b0;
    logic          aresetn      = 1'b0;
    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [CB-1:0] s_dir_x      = '0;
    logic [CB-1:0] s_dir_y      = '0;
    logic [CB-1:0] s_dir_z      = '0;
    logic          m_valid;
    logic          m_ready      = 1'b0;
    logic [cfuv_pkg::FaceBits-1:0] m_face;
    logic [FB-1:0] m_coord_u;
    logic [FB-1:0] m_coord_v;
    logic          m_degenerate;

    int mismatches;
    int owed;
    int idle_cycles = 0;

    // pacing knobs: steady means no gaps on that side, hold asks the
    // receiver for one long stall
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit rx_hold   = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cubemap_face_uv_select dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_dir_x      (s_dir_x),
        .s_dir_y      (s_dir_y),
        .s_dir_z      (s_dir_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_face       (m_face),
        .m_coord_u    (m_coord_u),
        .m_coord_v    (m_coord_v),
        .m_degenerate (m_degenerate)
    );

    cfuv_face_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_dir_x      (s_dir_x),
        .s_dir_y      (s_dir_y),
        .s_dir_z      (s_dir_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_face       (m_face),
        .m_coord_u    (m_coord_u),
        .m_coord_v    (m_coord_v),
        .m_degenerate (m_degenerate),
        .mismatches   (mismatches),
        .owed         (owed)
    );

    // offer one direction item and return at the edge that takes it;
    // valid stays high into the next item when no gap is drawn
    task automatic send_dir(input int x, input int y, input int z);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_dir_x <= x[CB-1:0];
        s_dir_y <= y[CB-1:0];
        s_dir_z <= z[CB-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until the checker owes nothing
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed != 0);
    endtask

    // values at the ends of the signed range and around zero
    function automatic int rim_value();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    // random direction, biased toward ties, tiny vectors and range ends,
    // rotated over the axes so every axis gets every shape
    task automatic random_dir(output int x, output int y, output int z);
        int a, b, c, m;
        case ($urandom_range(0, 9))
            4: begin
                // tiny components, ties and zero vectors come often
                a = int'($urandom_range(0, 6)) - 3;
                b = int'($urandom_range(0, 6)) - 3;
                c = int'($urandom_range(0, 6)) - 3;
            end
            5: begin
                // two axes tie in magnitude, third no larger
                m = $urandom_range(0, 32768);
                a = $urandom_range(0, 1) ? m : -m;
                b = $urandom_range(0, 1) ? m : -m;
                c = int'($urandom_range(0, 2 * m)) - m;
            end
            6: begin
                a = rim_value();
                b = rim_value();
                c = rim_value();
            end
            7: begin
                // one axis at a range end, the others anywhere
                a = $urandom_range(0, 1) ? 32767 : -32768;
                b = $urandom;
                c = $urandom;
            end
            8: begin
                // zero vector or a single small axis
                a = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 4)) - 2;
                b = 0;
                c = 0;
            end
            9: begin
                // all three share one magnitude, signs random
                m = $urandom_range(0, 32768);
                a = $urandom_range(0, 1) ? m : -m;
                b = $urandom_range(0, 1) ? m : -m;
                c = $urandom_range(0, 1) ? m : -m;
            end
            default: begin
                a = $urandom;
                b = $urandom;
                c = $urandom;
            end
        endcase
        case ($urandom_range(0, 2))
            0:       begin x = a; y = b; z = c; end
            1:       begin x = b; y = c; z = a; end
            default: begin x = c; y = a; z = b; end
        endcase
    endtask

    // receiver: random stall before each result, one long hold on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (rx_hold) begin
                stall   = HOLD_CYCLES;
                rx_hold = 1'b0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int x, y, z;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero vector, then one clear case per face
        send_dir(0, 0, 0);
        send_dir(1000, 200, -300);
        send_dir(-1000, 200, -300);
        send_dir(200, 1000, -300);
        send_dir(200, -1000, -300);
        send_dir(-200, 300, 1000);
        send_dir(-200, 300, -1000);
        // range ends on the major axis
        send_dir(32767, 0, 0);
        send_dir(-32768, 0, 0);
        send_dir(0, 32767, -32768);
        send_dir(0, -32768, 32767);
        send_dir(-32768, 32767, 32767);
        // full three-way ties go to z, coordinates land on 0 or saturate
        send_dir(-32768, -32768, -32768);
        send_dir(32767, 32767, 32767);
        // pairwise ties: x/y goes to y, x/z and y/z go to z
        send_dir(100, 100, 5);
        send_dir(-100, 5, 100);
        send_dir(5, -100, -100);
        // smallest magnitudes and truncation of odd quotients
        send_dir(1, 0, 0);
        send_dir(0, 0, -1);
        send_dir(1, -1, 1);
        send_dir(-1, 1, -1);
        send_dir(3, -2, 1);
        send_dir(-7, 3, -5);
        send_dir(0, 0, 1);
        // sender waits for every result before going on
        drain_results();

        // back-to-back items against a long output stall: the divider
        // chain fills and the input side has to back off
        tx_steady = 1'b1;
        rx_hold   = 1'b1;
        repeat (PRESS_ITEMS) begin
            random_dir(x, y, z);
            send_dir(x, y, z);
        end
        tx_steady = 1'b0;
        drain_results();

        // random part, pacing mixed per block so gaps hit every stage
        repeat (RAND_BLOCKS) begin
            case ($urandom_range(0, 3))
                0:       begin tx_steady = 1'b0; rx_steady = 1'b0; end
                1:       begin tx_steady = 1'b1; rx_steady = 1'b0; end
                2:       begin tx_steady = 1'b0; rx_steady = 1'b1; end
                default: begin tx_steady = 1'b1; rx_steady = 1'b1; end
            endcase
            repeat (BLOCK_ITEMS) begin
                random_dir(x, y, z);
                send_dir(x, y, z);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        // nothing should come out after the last owed result
        repeat (LATENCY + 8) @(posedge aclk);
        if (mismatches == 0 && owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/cfuv_pkg.sv
sv/cfuv_front.sv
sv/cfuv_div_cell.sv
sv/cubemap_face_uv_select.sv
sv/cfuv_checker.sv
sim/cfuv_face_checker.sv
sim/cubemap_face_uv_select_tb.sv
